// ===== sv/kbct_pkg.sv =====
// Package: shared types and constants of the k-best convergence tracker.
`timescale 1ns / 1ps

package kbct_pkg;

  // Field widths
  localparam int CYCLES_W    = 31;
  localparam int RANK_W      = 11;
  localparam int RATIO_W     = 24;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Store depth default
  localparam int MAX_RUNS_DEF = 1024;

  // Value of a store entry that holds no run
  localparam logic [CYCLES_W-1:0] SENTINEL_CYCLES = 31'd9999999;
  localparam logic [RATIO_W-1:0]  RATIO_MAX       = 24'hFFFFFF;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_K_RANK    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RUNS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd2;

  // Register reset values
  localparam logic [RANK_W-1:0]  K_RANK_RST    = 11'd3;
  localparam logic [RANK_W-1:0]  MAX_RUNS_RST  = 11'd10;
  localparam logic [RATIO_W-1:0] TOLERANCE_RST = 24'd13107;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_CONTINUE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_GAVE_UP   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

  typedef struct packed {
    logic [CYCLES_W-1:0] run_cycles;
    logic                new_series;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   run_count;
    logic [CYCLES_W-1:0] fastest_cycles;
    logic [CYCLES_W-1:0] kth_cycles;
    logic [RATIO_W-1:0]  kth_ratio;
  } out_t;

endpackage

// ===== sv/kbct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kbct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kbest_convergence_tracker_top.sv =====
// Top level: k-best convergence tracker with sorted run store and divider.
// Each run passes the insertion walk, the store reads, the bit-serial divider and the
//   result step in turn; an ignored run, or one that meets a full store, skips the walk.
// Runs are taken one at a time: a new run is accepted only in idle, once the result
//   has loaded, so the walk, the divider and output stalls set the rate.
// Reset: registers 3 / 10 / 13107, run count 0, series over; unfilled entries read 9999999.
`timescale 1ns / 1ps

module kbest_convergence_tracker_top
  import kbct_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_RUNS);
  localparam int CNT_W  = $clog2(MAX_RUNS + 1);
  localparam int QUO_W  = RATIO_W + 1;
  localparam int DCNT_W = $clog2(QUO_W + 1);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_RD0   = 3'd2;
  localparam logic [2:0] ST_RDK   = 3'd3;
  localparam logic [2:0] ST_CAPK  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]          state;
  logic [RANK_W-1:0]   k_rank;
  logic [RANK_W-1:0]   max_runs;
  logic [RATIO_W-1:0]  tolerance;
  logic [CNT_W-1:0]    runs_done;
  logic                series_over;
  logic                active;

  logic [CYCLES_W-1:0] cyc;
  logic [ADDR_W-1:0]   pos;
  logic [CYCLES_W-1:0] fastest;
  logic [CYCLES_W-1:0] kth;
  logic [CYCLES_W-1:0] rem;
  logic [QUO_W-1:0]    dvd;
  logic [QUO_W-1:0]    quo;
  logic [DCNT_W-1:0]   div_cnt;
  logic                sat;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CYCLES_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CYCLES_W-1:0] mem_rdata;

  logic [CNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    runs_eff;
  logic                in_xfer;
  logic                shift_on;
  logic [CYCLES_W-1:0] kth_val;
  logic [CYCLES_W:0]   trial;
  logic                trial_ge;
  logic [QUO_W-1:0]    tol_lim;
  logic                conv;
  logic                limit_hit;
  logic [RATIO_W-1:0]  ratio;
  logic [STATUS_W-1:0] status;
  logic                out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // Clamp rank and run limit into 1..MAX_RUNS
  always_comb begin
    if (k_rank == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(k_rank) > 32'(MAX_RUNS)) begin
      k_eff = CNT_W'(MAX_RUNS);
    end else begin
      k_eff = CNT_W'(k_rank);
    end
    if (max_runs == '0) begin
      limit = CNT_W'(1);
    end else if (32'(max_runs) > 32'(MAX_RUNS)) begin
      limit = CNT_W'(MAX_RUNS);
    end else begin
      limit = CNT_W'(max_runs);
    end
  end

  // Run count seen by the incoming item
  assign runs_eff = in_data.new_series ? '0 : runs_done;

  // Insertion walk: move larger entries up one place, then drop the run in
  assign shift_on  = (pos != '0) && (mem_rdata > cyc);
  assign mem_we    = (state == ST_SHIFT);
  assign mem_waddr = pos;
  assign mem_wdata = shift_on ? mem_rdata : cyc;

  // Store read address by step
  always_comb begin
    unique case (state)
      ST_IDLE:  mem_raddr = ADDR_W'(runs_eff - CNT_W'(1));
      ST_SHIFT: mem_raddr = pos - ADDR_W'(2);
      ST_RDK:   mem_raddr = ADDR_W'(k_eff - CNT_W'(1));
      default:  mem_raddr = '0;
    endcase
  end

  kbct_ram #(
    .WIDTH (CYCLES_W),
    .DEPTH (MAX_RUNS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Rank entry beyond the fill count reads as the sentinel
  assign kth_val = (k_eff > runs_done) ? SENTINEL_CYCLES : mem_rdata;

  // Divider step: quotient of kth * 2^16 / fastest, one bit a cycle
  assign trial    = {rem, dvd[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, fastest};

  // Converged when kth * 2^16 / fastest <= tolerance + 1.0, exact: a quotient
  // equal to the bound passes only with a zero remainder
  assign tol_lim   = {1'b0, tolerance} + QUO_W'(32'h10000);
  assign conv      = !sat && ((quo < tol_lim) || ((quo == tol_lim) && (rem == '0)));
  assign limit_hit = (runs_done >= limit);
  assign ratio     = (sat || quo[QUO_W-1]) ? RATIO_MAX : quo[RATIO_W-1:0];

  always_comb begin
    priority if (!active) begin
      status = STATUS_IGNORED;
    end else if (conv) begin
      status = STATUS_CONVERGED;
    end else if (limit_hit) begin
      status = STATUS_GAVE_UP;
    end else begin
      status = STATUS_CONTINUE;
    end
  end

  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      k_rank      <= K_RANK_RST;
      max_runs    <= MAX_RUNS_RST;
      tolerance   <= TOLERANCE_RST;
      runs_done   <= '0;
      series_over <= 1'b1;
      active      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Configuration writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_K_RANK:    k_rank    <= cfg_data[RANK_W-1:0];
          REG_MAX_RUNS:  max_runs  <= cfg_data[RANK_W-1:0];
          REG_TOLERANCE: tolerance <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data.new_series) begin
              runs_done   <= '0;
              series_over <= 1'b0;
            end
            active <= in_data.new_series || !series_over;
            if ((in_data.new_series || !series_over) && (runs_eff != CNT_W'(MAX_RUNS))) begin
              state <= ST_SHIFT;
            end else begin
              state <= ST_RD0;
            end
          end
        end
        ST_SHIFT: begin
          if (!shift_on) begin
            runs_done <= runs_done + CNT_W'(1);
            state     <= ST_RD0;
          end
        end
        ST_RD0:  state <= ST_RDK;
        ST_RDK:  state <= ST_CAPK;
        ST_CAPK: state <= ST_DIV;
        ST_DIV: begin
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (active && (conv || limit_hit)) begin
              series_over <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cyc <= in_data.run_cycles;
      pos <= ADDR_W'(runs_eff);
    end
    if (state == ST_SHIFT && shift_on) begin
      pos <= pos - ADDR_W'(1);
    end
    if (state == ST_RDK) begin
      fastest <= (runs_done == '0) ? SENTINEL_CYCLES : mem_rdata;
    end
    // Divider setup; quotient of 25 bits or saturation
    if (state == ST_CAPK) begin
      kth     <= kth_val;
      rem     <= CYCLES_W'(kth_val >> (QUO_W - 16));
      dvd     <= {kth_val[QUO_W-17:0], 16'b0};
      quo     <= '0;
      div_cnt <= DCNT_W'(QUO_W);
      sat     <= (fastest == '0) ||
                 ({{QUO_W-16{1'b0}}, kth_val} >= {fastest, {QUO_W-16{1'b0}}});
    end
    if (state == ST_DIV) begin
      rem     <= trial_ge ? CYCLES_W'(trial - {1'b0, fastest}) : CYCLES_W'(trial);
      quo     <= {quo[QUO_W-2:0], trial_ge};
      dvd     <= {dvd[QUO_W-2:0], 1'b0};
      div_cnt <= div_cnt - DCNT_W'(1);
    end
    if (out_load) begin
      out_data.status         <= status;
      out_data.run_count      <= RANK_W'(runs_done);
      out_data.fastest_cycles <= fastest;
      out_data.kth_cycles     <= kth;
      out_data.kth_ratio      <= ratio;
    end
  end

  // Run count never passes the store depth
  a_runs_bound: assert property (@(posedge clk) disable iff (rst)
    32'(runs_done) <= 32'(MAX_RUNS))
    else $error("run count beyond store depth");

  // Store writes stay inside the filled region plus one
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CNT_W'(pos) <= runs_done) && (runs_done != CNT_W'(MAX_RUNS)))
    else $error("store write outside filled region");

  // An ignored run leaves the run count alone
  a_ignored_stable: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !in_data.new_series && series_over) |=> $stable(runs_done))
    else $error("ignored run changed run count");

  // A result only appears out of the final step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside final step");

  // Convergence never reported against a zero fastest time
  a_conv_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_load && active && conv) |-> (fastest != '0))
    else $error("converged with zero fastest time");

endmodule
